// ----- rtl/grid_path_exists_dfs_unit_defines.svh -----
// ----------------------------------------------------------------------------
// grid path unit assertion macros
// shared check templates, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef GRID_PATH_EXISTS_DFS_UNIT_DEFINES_SVH
`define GRID_PATH_EXISTS_DFS_UNIT_DEFINES_SVH

// same-cycle implication
`define GPD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define GPD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/gpd_pkg.sv -----
// ----------------------------------------------------------------------------
// gpd_pkg
// shared types and constants of the grid path search unit
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int CNT_W     = 7;
  localparam int POS_W     = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef struct packed {
    logic accept;
    logic last;
    logic div_start;
    logic clr_step;
    logic seed;
    logic issue;
    dir_t dir;
    logic pop;
    logic fetch;
    logic res_load;
    logic res_found;
  } gpd_cmd_t;

  typedef struct packed {
    logic cols_wr;
    logic div_busy;
    logic clr_last;
    logic start_goal;
    logic take;
    logic nb_goal;
    logic stack_empty;
    logic top_goal;
    logic out_busy;
  } gpd_status_t;

endpackage

// ----- rtl/gpd_channels.sv -----
// ----------------------------------------------------------------------------
// gpd channels
// valid/ready channels for grid cells and search results
// ----------------------------------------------------------------------------
interface gpd_cell_if;
  logic valid;
  logic ready;
  logic cell_open;
  logic last_cell;

  modport source (output valid, output cell_open, output last_cell, input ready);
  modport sink (input valid, input cell_open, input last_cell, output ready);
endinterface

interface gpd_result_if;
  logic valid;
  logic ready;
  logic path_found;

  modport source (output valid, output path_found, input ready);
  modport sink (input valid, input path_found, output ready);
endinterface

// ----- rtl/gpd_datapath.sv -----
// ----------------------------------------------------------------------------
// gpd_datapath
// config registers, grid and visited maps, search stack, load position
// divider and result register
// ----------------------------------------------------------------------------
module gpd_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gpd_pkg::gpd_cmd_t                cmd,
  output gpd_pkg::gpd_status_t             st,
  input  logic                             in_open,
  input  logic                             cfg_we,
  input  logic [gpd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [gpd_pkg::CNT_W-1:0]        cfg_data,
  output logic                             out_valid,
  output logic                             out_found,
  input  logic                             out_ready
);
  import gpd_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RU_W   = ROW_W + 1;
  localparam int CU_W   = COL_W + 1;
  localparam int RC_W   = (RU_W > CNT_W) ? RU_W : CNT_W;
  localparam int CC_W   = (CU_W > CNT_W) ? CU_W : CNT_W;
  localparam int CR_W   = (ROW_W > POS_W) ? ROW_W : POS_W;
  localparam int CCO_W  = (COL_W > POS_W) ? COL_W : POS_W;
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int IDX_W  = $clog2(CELLS + 1);
  localparam int STK_AW = $clog2(CELLS);
  localparam int MAP_AW = ROW_W + COL_W;
  localparam int MAP_D  = 2 ** MAP_AW;
  localparam int ENT_W  = ROW_W + COL_W;
  localparam int DC_W   = $clog2(IDX_W + 1);

  // configuration
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [POS_W-1:0] start_row;
  logic [POS_W-1:0] start_col;
  logic [POS_W-1:0] goal_row;
  logic [POS_W-1:0] goal_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(10);
      col_count <= CNT_W'(10);
      start_row <= '0;
      start_col <= '0;
      goal_row  <= '0;
      goal_col  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        REG_START_ROW: start_row <= cfg_data[POS_W-1:0];
        REG_START_COL: start_col <= cfg_data[POS_W-1:0];
        REG_GOAL_ROW:  goal_row  <= cfg_data[POS_W-1:0];
        REG_GOAL_COL:  goal_col  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size
  logic [RC_W-1:0] row_cnt_x;
  logic [CC_W-1:0] col_cnt_x;
  logic [RU_W-1:0] rows_use;
  logic [CU_W-1:0] cols_use;

  always_comb begin
    row_cnt_x = RC_W'(row_count);
    col_cnt_x = CC_W'(col_count);
    if (row_count == '0) begin
      rows_use = RU_W'(1);
    end else if (row_cnt_x > RC_W'(MAX_ROWS)) begin
      rows_use = RU_W'(MAX_ROWS);
    end else begin
      rows_use = RU_W'(row_cnt_x);
    end
    if (col_count == '0) begin
      cols_use = CU_W'(1);
    end else if (col_cnt_x > CC_W'(MAX_COLS)) begin
      cols_use = CU_W'(MAX_COLS);
    end else begin
      cols_use = CU_W'(col_cnt_x);
    end
  end

  // load position and remap divider
  logic [IDX_W-1:0] load_index;
  logic [IDX_W-1:0] load_r;
  logic [COL_W-1:0] load_c;
  logic [IDX_W-1:0] div_q;
  logic [COL_W-1:0] div_rem;
  logic [DC_W-1:0]  div_cnt;
  logic [CU_W-1:0]  div_try;
  logic             div_ge;
  logic [COL_W-1:0] div_rem_next;
  logic [IDX_W-1:0] div_q_next;

  always_comb begin
    div_try      = {div_rem, div_q[IDX_W-1]};
    div_ge       = (div_try >= cols_use);
    div_rem_next = div_ge ? COL_W'(div_try - cols_use) : div_try[COL_W-1:0];
    div_q_next   = {div_q[IDX_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DC_W'(IDX_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - DC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= load_index;
      div_rem <= '0;
    end else if (div_cnt != '0) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      load_r     <= '0;
      load_c     <= '0;
    end else if (cmd.accept) begin
      if (cmd.last) begin
        load_index <= '0;
        load_r     <= '0;
        load_c     <= '0;
      end else if (load_index != IDX_W'(CELLS)) begin
        load_index <= load_index + IDX_W'(1);
        if (CU_W'(load_c) == cols_use - CU_W'(1)) begin
          load_c <= '0;
          load_r <= load_r + IDX_W'(1);
        end else begin
          load_c <= load_c + COL_W'(1);
        end
      end
    end else if (div_cnt == DC_W'(1)) begin
      load_r <= div_q_next;
      load_c <= div_rem_next;
    end
  end

  // clearing sweep over the visited map
  logic [ROW_W-1:0] clr_r;
  logic [COL_W-1:0] clr_c;
  logic             clr_last;
  logic             clr_row_end;

  assign clr_row_end = (CU_W'(clr_c) == cols_use - CU_W'(1));
  assign clr_last    = clr_row_end && (RU_W'(clr_r) == rows_use - RU_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.last) begin
      clr_r <= '0;
      clr_c <= '0;
    end else if (cmd.clr_step) begin
      if (clr_row_end) begin
        clr_c <= '0;
        clr_r <= clr_r + ROW_W'(1);
      end else begin
        clr_c <= clr_c + COL_W'(1);
      end
    end
  end

  // current cell and neighbor generation
  logic [CR_W-1:0]  cur_r;
  logic [CCO_W-1:0] cur_c;
  logic [CR_W:0]    nr;
  logic [CCO_W:0]   nc;
  logic             edge_ok;
  logic             in_grid;
  logic [MAP_AW-1:0] nb_addr;

  always_comb begin
    nr      = {1'b0, cur_r};
    nc      = {1'b0, cur_c};
    edge_ok = 1'b1;
    case (cmd.dir)
      DIR_N: begin
        edge_ok = (cur_r != '0);
        nr      = {1'b0, cur_r} - (CR_W+1)'(1);
      end
      DIR_E: nc = {1'b0, cur_c} + (CCO_W+1)'(1);
      DIR_S: nr = {1'b0, cur_r} + (CR_W+1)'(1);
      DIR_W: begin
        edge_ok = (cur_c != '0);
        nc      = {1'b0, cur_c} - (CCO_W+1)'(1);
      end
      default: edge_ok = 1'b0;
    endcase
    in_grid = edge_ok && (nr < (CR_W+1)'(rows_use)) && (nc < (CCO_W+1)'(cols_use));
    nb_addr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
  end

  logic             nb_v_q;
  logic [ROW_W-1:0] nb_r_q;
  logic [COL_W-1:0] nb_c_q;
  logic             free_q;
  logic             vis_q;
  logic             take;
  logic             push;
  logic             pop_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_v_q <= 1'b0;
    end else begin
      nb_v_q <= cmd.issue && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    nb_r_q <= nr[ROW_W-1:0];
    nb_c_q <= nc[COL_W-1:0];
  end

  // grid map
  logic free_map [MAP_D];

  always_ff @(posedge clk) begin
    if (cmd.accept && (load_r < IDX_W'(rows_use))) begin
      free_map[{load_r[ROW_W-1:0], load_c}] <= in_open;
    end
    free_q <= free_map[nb_addr];
  end

  // visited map
  logic               visited [MAP_D];
  logic               vis_we;
  logic [MAP_AW-1:0]  vis_wa;
  logic               vis_wd;
  logic [CR_W-1:0]    start_r_x;
  logic [CCO_W-1:0]   start_c_x;
  logic               start_in;

  assign start_r_x = CR_W'(start_row);
  assign start_c_x = CCO_W'(start_col);
  assign start_in  = ((CR_W+1)'(start_row) < (CR_W+1)'(rows_use)) &&
                     ((CCO_W+1)'(start_col) < (CCO_W+1)'(cols_use));

  assign take   = nb_v_q && free_q && !vis_q;
  assign push   = take && !cmd.pop;

  always_comb begin
    vis_we = 1'b0;
    vis_wa = {nb_r_q, nb_c_q};
    vis_wd = 1'b1;
    if (cmd.clr_step) begin
      vis_we = 1'b1;
      vis_wa = {clr_r, clr_c};
      vis_wd = 1'b0;
    end else if (cmd.seed) begin
      vis_we = start_in;
      vis_wa = {start_r_x[ROW_W-1:0], start_c_x[COL_W-1:0]};
    end else if (take) begin
      vis_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      visited[vis_wa] <= vis_wd;
    end
    vis_q <= visited[nb_addr];
  end

  // search stack
  logic [ENT_W-1:0] cell_stack [CELLS];
  logic [IDX_W-1:0] depth;
  logic [IDX_W-1:0] depth_m1;
  logic [ENT_W-1:0] stk_q;

  assign depth_m1 = depth - IDX_W'(1);
  assign pop_rd   = cmd.pop && !take && (depth != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      cell_stack[depth[STK_AW-1:0]] <= {nb_r_q, nb_c_q};
    end
    if (pop_rd) begin
      stk_q <= cell_stack[depth_m1[STK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.seed) begin
      depth <= '0;
    end else if (push) begin
      depth <= depth + IDX_W'(1);
    end else if (pop_rd) begin
      depth <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      cur_r <= start_r_x;
      cur_c <= start_c_x;
    end else if (cmd.pop && take) begin
      cur_r <= CR_W'(nb_r_q);
      cur_c <= CCO_W'(nb_c_q);
    end else if (cmd.fetch) begin
      cur_r <= CR_W'(stk_q[ENT_W-1:COL_W]);
      cur_c <= CCO_W'(stk_q[COL_W-1:0]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_found <= cmd.res_found;
    end
  end

  // status
  always_comb begin
    st.cols_wr     = cfg_we && (cfg_index == REG_COL_COUNT);
    st.div_busy    = (div_cnt != '0);
    st.clr_last    = clr_last;
    st.start_goal  = (start_row == goal_row) && (start_col == goal_col);
    st.take        = take;
    st.nb_goal     = (CR_W'(nb_r_q) == CR_W'(goal_row)) &&
                     (CCO_W'(nb_c_q) == CCO_W'(goal_col));
    st.stack_empty = (depth == '0);
    st.top_goal    = (CR_W'(stk_q[ENT_W-1:COL_W]) == CR_W'(goal_row)) &&
                     (CCO_W'(stk_q[COL_W-1:0]) == CCO_W'(goal_col));
    st.out_busy    = out_valid && !out_ready;
  end

`include "grid_path_exists_dfs_unit_defines.svh"

  `GPD_ASSERT_IMP(a_push_room, push, depth != IDX_W'(CELLS), "stack push when full")
  `GPD_ASSERT_IMP(a_pop_filled, cmd.fetch, $past(pop_rd), "fetch without stack read")
  `GPD_ASSERT_IMP(a_load_div_idle, cmd.accept, div_cnt == '0, "cell taken during remap")
  `GPD_ASSERT_IMP(a_res_free, cmd.res_load, !(out_valid && !out_ready), "result overwritten")
  `GPD_ASSERT_NEXT(a_push_depth, push && !cmd.seed, depth == $past(depth) + IDX_W'(1), "depth slip")

endmodule

// ----- rtl/gpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gpd_ctrl
// sequencer for grid load, remap, visited clear, depth-first search and
// result handoff
// ----------------------------------------------------------------------------
module gpd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output gpd_pkg::gpd_cmd_t    cmd,
  input  gpd_pkg::gpd_status_t st
);
  import gpd_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_REMAP = 8'b0000_0010,
    S_CLEAR = 8'b0000_0100,
    S_SEED  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_POP   = 8'b0010_0000,
    S_FETCH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  dir_t   dir;
  dir_t   dir_next;
  logic   found;
  logic   found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      dir   <= DIR_N;
      found <= 1'b0;
    end else begin
      state <= state_next;
      dir   <= dir_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next    = state;
    dir_next      = dir;
    found_next    = found;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.dir       = dir;
    cmd.res_found = found;
    case (state)
      S_LOAD: begin
        in_ready = !st.cols_wr;
        if (st.cols_wr) begin
          cmd.div_start = 1'b1;
          state_next    = S_REMAP;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.last   = in_last;
          if (in_last) begin
            state_next = S_CLEAR;
          end
        end
      end
      S_REMAP: begin
        if (st.cols_wr) begin
          cmd.div_start = 1'b1;
        end else if (!st.div_busy) begin
          state_next = S_LOAD;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed = 1'b1;
        dir_next = DIR_N;
        if (st.start_goal) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        dir_next  = dir_t'(dir + 2'd1);
        if (dir == DIR_W) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (st.take) begin
          dir_next = DIR_N;
          if (st.nb_goal) begin
            found_next = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (st.stack_empty) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        dir_next  = DIR_N;
        if (st.top_goal) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

// ----- rtl/grid_path_exists_dfs_unit.sv -----
// grid cells load at one per cycle unless a col_count write stalls input; an item
// without the last mark gives no result; after the last cell: a visited-map clear
// over rows*cols cells, a seed step, then per explored cell four neighbor reads on
// the map port and a pop; the result is registered once the previous one is taken,
// and the next grid loads meanwhile; a col_count write stalls input during the remap
// synchronous reset restores register defaults; grid and stack memories are not cleared
// ----------------------------------------------------------------------------
// grid_path_exists_dfs_unit
// maze reachability by stack-based depth-first search over a loaded grid
// ----------------------------------------------------------------------------
module grid_path_exists_dfs_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  gpd_cell_if.sink                         cells,
  gpd_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [gpd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [gpd_pkg::CNT_W-1:0]        cfg_data
);
  import gpd_pkg::*;

  gpd_cmd_t    cmd;
  gpd_status_t st;
  logic        in_ready;
  logic        out_valid;
  logic        out_found;

  gpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cells.valid),
    .in_last  (cells.last_cell),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  gpd_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_open   (cells.cell_open),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_ready (result.ready)
  );

  assign cells.ready       = in_ready;
  assign result.valid      = out_valid;
  assign result.path_found = out_found;

endmodule
